[sv/dapt_pkg.sv]
// ----------------------------------------------------------------------------
// dapt_pkg
// Shared field widths and register reset value for the double arithmetic
// progression tail checker.
// ----------------------------------------------------------------------------
package dapt_pkg;

  // input position field and reported gap field
  localparam int unsigned POS_W = 10;
  localparam int unsigned GAP_W = 10;

  // progression length register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  // result stream: passes, offending_gap, padded to whole bytes
  localparam int unsigned M_TDATA_W = ((1 + GAP_W + 7) / 8) * 8;

endpackage

[sv/double_ap_tail_checker.sv]
// ----------------------------------------------------------------------------
// double_ap_tail_checker
// Stores one value per transaction at a given position, cuts the sequence to
// that position plus one, and checks whether the new tail element ends a
// double arithmetic progression of the configured length.
// ----------------------------------------------------------------------------
// With nothing to read (lengths 0 and 1, or no gap fits) the result goes from
// IDLE through FINISH to the output register; otherwise every stored element
// read passes ISSUE and CHECK, summed over the gaps tried (each gap reads up to
// progression length - 1 elements, stopping at the first mismatch).
// One transaction at a time: a new item is accepted only in IDLE.
// Reset clears control state and sets the progression length to 4 only.
module double_ap_tail_checker #(
  parameter int unsigned MAX_LENGTH  = 1024,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  // configuration
  input  logic                                           cfg_we,
  input  logic [dapt_pkg::CFG_W-1:0]                     cfg_wdata,
  // input stream
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // fields from bit 0: position, element_value
  input  logic [((dapt_pkg::POS_W+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // result stream
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // fields from bit 0: passes, offending_gap
  output logic [dapt_pkg::M_TDATA_W-1:0]                 m_axis_tdata
);

  import dapt_pkg::*;

  localparam int unsigned ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LEN_W  = POS_W + 1;
  localparam int unsigned LIM_W  = LEN_W + 1;
  localparam int unsigned DIFF_W = VALUE_WIDTH + 1;

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]             state;
  logic [CFG_W-1:0]       plen;

  // sequence memory
  logic [VALUE_WIDTH-1:0] mem [MAX_LENGTH];
  logic [VALUE_WIDTH-1:0] rdata;

  // search registers
  logic [POS_W-1:0]       last;
  logic [LEN_W-1:0]       len;
  logic [VALUE_WIDTH-1:0] newval;
  logic [VALUE_WIDTH-1:0] prev;
  logic [POS_W-1:0]       idx;
  logic [GAP_W-1:0]       gap;
  logic [LIM_W-1:0]       lim;
  logic [CFG_W-1:0]       k;
  logic signed [DIFF_W-1:0] step;
  logic                   res_pass;
  logic [GAP_W-1:0]       res_gap;

  logic                   in_accept;
  logic [POS_W-1:0]       in_pos;
  logic [POS_W-1:0]       pos_sat;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [CFG_W-1:0]       span;
  logic signed [DIFF_W-1:0] diff;
  logic                   match;
  logic [GAP_W-1:0]       gap_next;
  logic [LIM_W-1:0]       lim_next;
  logic [LIM_W-1:0]       lim_first;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_pos        = s_axis_tdata[POS_W-1:0];
  assign in_val        = s_axis_tdata[POS_W+VALUE_WIDTH-1:POS_W];

  // saturate the position to the last memory entry
  always_comb begin
    if (32'(in_pos) >= MAX_LENGTH) begin
      pos_sat = POS_W'(MAX_LENGTH - 1);
    end else begin
      pos_sat = in_pos;
    end
  end

  // exact difference of neighbors and loop bookkeeping
  always_comb begin
    span      = plen - CFG_W'(1);
    lim_first = LIM_W'(span);
    diff      = $signed({prev[VALUE_WIDTH-1], prev}) - $signed({rdata[VALUE_WIDTH-1], rdata});
    match     = (k == CFG_W'(1)) || (diff == step);
    gap_next  = gap + GAP_W'(1);
    lim_next  = lim + LIM_W'(span);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= CFG_RESET;
    end else if (cfg_we) begin
      plen <= cfg_wdata;
    end
  end

  // memory write on accept, registered read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem[ADDR_W'(pos_sat)] <= in_val;
    end
    if (state == ST_ISSUE) begin
      rdata <= mem[ADDR_W'(idx)];
    end
  end

  // search controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            last   <= pos_sat;
            len    <= LEN_W'(pos_sat) + LEN_W'(1);
            newval <= in_val;
            prev   <= in_val;
            gap    <= GAP_W'(1);
            lim    <= lim_first;
            k      <= CFG_W'(1);
            idx    <= pos_sat - POS_W'(1);
            res_gap <= '0;
            priority if (plen == '0) begin
              res_pass <= 1'b1;
              state    <= ST_FINISH;
            end else if (plen == CFG_W'(1)) begin
              res_pass <= 1'b0;
              state    <= ST_FINISH;
            end else if (lim_first >= LIM_W'(pos_sat) + LIM_W'(1)) begin
              res_pass <= 1'b1;
              state    <= ST_FINISH;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (k == CFG_W'(1)) begin
            step <= diff;
          end
          priority if (match && (k == span)) begin
            // progression found at this gap
            res_pass <= 1'b0;
            res_gap  <= gap;
            state    <= ST_FINISH;
          end else if (match) begin
            // walk one more element back
            k     <= k + CFG_W'(1);
            prev  <= rdata;
            idx   <= idx - POS_W'(gap);
            state <= ST_ISSUE;
          end else if (lim_next >= LIM_W'(len)) begin
            // no further gap fits
            res_pass <= 1'b1;
            res_gap  <= '0;
            state    <= ST_FINISH;
          end else begin
            // try the next gap from the tail
            gap   <= gap_next;
            lim   <= lim_next;
            k     <= CFG_W'(1);
            prev  <= newval;
            idx   <= last - POS_W'(gap_next);
            state <= ST_ISSUE;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= M_TDATA_W'({res_gap, res_pass});
    end
  end

endmodule
